>>> rtl/core/gwuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwuc_pkg: shared definitions for the grid window unknown count block
// Sizes of the cell store, field widths, class and register codes, the
// sequencer state type and the cell classifier.
// ----------------------------------------------------------------------------
package gwuc_pkg;

    // Store geometry and window limit.
    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;
    localparam int MAX_RADIUS  = 63;

    // Field and register widths.
    localparam int FIELD_W   = 9;
    localparam int VALUE_W   = 8;
    localparam int DIM_W     = 10;
    localparam int RADIUS_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;
    localparam int OUT_W     = 15;

    // Derived widths.
    localparam int MAP_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int COL_W     = $clog2(MAX_COLUMNS);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COORD_W   = $clog2((2 ** DIM_W) + MAX_RADIUS + 1) + 1;
    localparam int SQ_IN_W   = 2 * RADIUS_W;
    localparam int SUM_W     = $clog2((2 * MAX_RADIUS + 1) * 2 * MAX_RADIUS + 1) + 2;
    localparam int GAIN_MAX  = 2 ** (OUT_W - 1) - 1;
    localparam int GAIN_MIN  = -(2 ** (OUT_W - 1));

    // Cell classes.
    localparam logic [1:0] CLS_OTHER    = 2'd0;
    localparam logic [1:0] CLS_UNKNOWN  = 2'd1;
    localparam logic [1:0] CLS_OCCUPIED = 2'd2;

    // Item functions.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Window shapes.
    localparam logic SHAPE_RECT = 1'b0;
    localparam logic SHAPE_DISC = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_CELLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SHAPE = 2'd3;

    // Query sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SQRT,
        S_CLIP,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } gwuc_state_t;

    // Square root unit request and response.
    typedef struct packed {
        logic               start;
        logic [SQ_IN_W-1:0] n;
    } sq_req_t;

    typedef struct packed {
        logic                done;
        logic [RADIUS_W-1:0] root;
    } sq_rsp_t;

    // Class of an occupancy value: unknown, occupied or other.
    function automatic logic [1:0] classify(input logic signed [VALUE_W-1:0] v);
        logic [1:0] c;
        if (v inside {-8'sd1, [8'sd46:8'sd54]})
        begin
            c = CLS_UNKNOWN;
        end
        else if (v == 8'sd100)
        begin
            c = CLS_OCCUPIED;
        end
        else
        begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/gwuc_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwuc_isqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle. The root is
// RADIUS_W bits wide.
// ----------------------------------------------------------------------------
module gwuc_isqrt (
    input  wire                clk,
    input  wire                rst_n,
    input  gwuc_pkg::sq_req_t  req,
    output gwuc_pkg::sq_rsp_t  rsp
);
    import gwuc_pkg::*;

    localparam int CNT_W = $clog2(RADIUS_W + 1);

    logic [SQ_IN_W-1:0]  n_reg, n_next;
    logic [RADIUS_W+1:0] rem_reg, rem_next;
    logic [RADIUS_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [RADIUS_W+2:0] rem_shift;
    logic [RADIUS_W+2:0] trial;

    // One root bit: bring down two bits of the operand and try the subtraction.
    always_comb
    begin
        rem_shift = {rem_reg[RADIUS_W:0], n_reg[SQ_IN_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            n_next    = req.n;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RADIUS_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[SQ_IN_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = (RADIUS_W + 2)'(rem_shift - trial);
                root_next = {root_reg[RADIUS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = (RADIUS_W + 2)'(rem_shift);
                root_next = {root_reg[RADIUS_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state is reset; the datapath needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule
`default_nettype wire

>>> rtl/core/grid_window_unknown_count.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_window_unknown_count: occupancy grid window gain
// Stores a 2-bit class per map cell and answers window queries with the
// number of unknown cells minus occupied cells around a centre cell.
// ----------------------------------------------------------------------------
//  Channel   Signals                                  Moves
//  input     in_valid/in_ready, func column row       one write or query word
//            cell_value
//  output    out_valid/out_ready, gain_count          one count word per query
//  config    cfg_we, cfg_index, cfg_data              one register write
//
// A write word is stored as it is taken. A query walks the window one row
// at a time: row setup (plus the square root unit for a disc), then a read
// of each window cell inside the map through the single read port of the
// cell memory; the drain and done states close the query. The cell memory
// is not cleared at reset. A held result does not block new words; a
// finished query waits only for the output register to free.
// ----------------------------------------------------------------------------
module grid_window_unknown_count (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   func,
    input  wire  [gwuc_pkg::FIELD_W-1:0]          column,
    input  wire  [gwuc_pkg::FIELD_W-1:0]          row,
    input  wire  signed [gwuc_pkg::VALUE_W-1:0]   cell_value,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [gwuc_pkg::OUT_W-1:0]     gain_count,
    input  wire                                   cfg_we,
    input  wire  [gwuc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [gwuc_pkg::CFG_W-1:0]            cfg_data
);
    import gwuc_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]    map_width_reg;
    logic [DIM_W-1:0]    map_height_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                shape_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= DIM_W'(512);
            map_height_reg <= DIM_W'(512);
            radius_reg     <= RADIUS_W'(10);
            shape_reg      <= SHAPE_RECT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:    map_width_reg  <= cfg_data[DIM_W-1:0];
                REG_MAP_HEIGHT:   map_height_reg <= cfg_data[DIM_W-1:0];
                REG_RADIUS_CELLS: radius_reg     <= cfg_data[RADIUS_W-1:0];
                REG_WINDOW_SHAPE: shape_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    gwuc_state_t state_reg, state_next;

    logic [FIELD_W-1:0]        col_reg, col_next;
    logic [FIELD_W-1:0]        row_reg, row_next;
    logic signed [COORD_W-1:0] w_reg, w_next;
    logic signed [COORD_W-1:0] h_reg, h_next;
    logic [RADIUS_W-1:0]       r_reg, r_next;
    logic [SQ_IN_W-1:0]        rr_reg, rr_next;
    logic                      disc_reg, disc_next;
    logic signed [RADIUS_W:0]  dy_reg, dy_next;
    logic [RADIUS_W-1:0]       dx_reg, dx_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] xend_reg, xend_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]   gain_reg, gain_next;

    // Cell memory and its read pipeline.
    logic [1:0]        map_mem [MAP_DEPTH];
    logic [1:0]        cls_reg;
    logic              rd_vld_reg;
    logic              rd_issue;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    // Square root unit.
    sq_req_t sq_req;
    sq_rsp_t sq_rsp;

    gwuc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    // Row geometry, all in signed coordinates.
    logic signed [COORD_W-1:0] col_s, row_s, dy_s, dx_s, r_s;
    logic signed [COORD_W-1:0] y_c, xs_c, xe_c, xs_clip, xe_clip;
    logic [RADIUS_W-1:0]       dy_mag;
    logic [SQ_IN_W-1:0]        dy_sq;
    logic                      row_last;
    logic                      in_acc;
    logic signed [SUM_W-1:0]   sum_acc;

    assign col_s    = $signed(COORD_W'(col_reg));
    assign row_s    = $signed(COORD_W'(row_reg));
    assign dy_s     = COORD_W'(dy_reg);
    assign dx_s     = $signed(COORD_W'(dx_reg));
    assign r_s      = $signed(COORD_W'(r_reg));
    assign y_c      = row_s + dy_s;
    assign xs_c     = col_s - dx_s;
    assign xe_c     = col_s + dx_s;
    assign xs_clip  = (xs_c < 0) ? '0 : xs_c;
    assign xe_clip  = (xe_c > w_reg) ? w_reg : xe_c;
    assign dy_mag   = dy_reg[RADIUS_W] ? RADIUS_W'(-dy_reg) : dy_reg[RADIUS_W-1:0];
    assign dy_sq    = SQ_IN_W'(dy_mag * dy_mag);
    assign row_last = (COORD_W'(dy_reg) == r_s);
    assign in_acc   = in_valid && in_ready;

    // Addresses of the cell being written and of the cell being scanned.
    assign wr_en   = in_acc && (func == FUNC_WRITE)
                     && (int'(column) < MAX_COLUMNS) && (int'(row) < MAX_ROWS);
    assign wr_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(column));
    assign rd_addr = ADDR_W'(ADDR_W'(y_reg[ROW_W-1:0]) * ADDR_W'(MAX_COLUMNS)
                     + ADDR_W'(x_reg[COL_W-1:0]));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= classify(cell_value);
        end
        if (rd_issue)
        begin
            cls_reg <= map_mem[rd_addr];
        end
    end

    // Add one for an unknown cell, subtract one for an occupied cell.
    always_comb
    begin
        sum_acc = sum_reg;
        if (rd_vld_reg)
        begin
            case (cls_reg)
                CLS_UNKNOWN:  sum_acc = sum_reg + SUM_W'(1);
                CLS_OCCUPIED: sum_acc = sum_reg - SUM_W'(1);
                default:      sum_acc = sum_reg;
            endcase
        end
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        r_next         = r_reg;
        rr_next        = rr_reg;
        disc_next      = disc_reg;
        dy_next        = dy_reg;
        dx_next        = dx_reg;
        y_next         = y_reg;
        x_next         = x_reg;
        xend_next      = xend_reg;
        sum_next       = sum_acc;
        out_valid_next = out_valid_reg && !out_ready;
        gain_next      = gain_reg;
        rd_issue       = 1'b0;
        sq_req.start   = 1'b0;
        sq_req.n       = SQ_IN_W'(rr_reg - dy_sq);
        in_ready       = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                // Latch the query and the clamped window geometry.
                if (in_acc && (func == FUNC_QUERY))
                begin
                    col_next   = column;
                    row_next   = row;
                    w_next     = (int'(map_width_reg) > MAX_COLUMNS)
                                 ? COORD_W'(MAX_COLUMNS) : $signed(COORD_W'(map_width_reg));
                    h_next     = (int'(map_height_reg) > MAX_ROWS)
                                 ? COORD_W'(MAX_ROWS) : $signed(COORD_W'(map_height_reg));
                    r_next     = (int'(radius_reg) > MAX_RADIUS)
                                 ? RADIUS_W'(MAX_RADIUS) : radius_reg;
                    rr_next    = SQ_IN_W'(r_next * r_next);
                    disc_next  = (shape_reg == SHAPE_DISC);
                    dy_next    = -$signed({1'b0, r_next});
                    sum_next   = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                // Half width of this row: the radius, or a square root for a disc.
                if (disc_reg)
                begin
                    sq_req.start = 1'b1;
                    state_next   = S_SQRT;
                end
                else
                begin
                    dx_next    = r_reg;
                    state_next = S_CLIP;
                end
            end
            S_SQRT:
            begin
                if (sq_rsp.done)
                begin
                    dx_next    = sq_rsp.root;
                    state_next = S_CLIP;
                end
            end
            S_CLIP:
            begin
                // Clip the row to the map; skip it when nothing is left.
                if ((y_c < 0) || (y_c >= h_reg) || (xs_clip >= xe_clip))
                begin
                    if (row_last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    y_next     = y_c;
                    x_next     = xs_clip;
                    xend_next  = xe_clip;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // One cell read per cycle.
                rd_issue = 1'b1;
                x_next   = x_reg + 1'b1;
                if (x_next == xend_reg)
                begin
                    if (row_last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Saturate into the output register once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    if (sum_reg > SUM_W'(GAIN_MAX))
                    begin
                        gain_next = OUT_W'(GAIN_MAX);
                    end
                    else if (sum_reg < SUM_W'(GAIN_MIN))
                    begin
                        gain_next = OUT_W'(GAIN_MIN);
                    end
                    else
                    begin
                        gain_next = OUT_W'(sum_reg);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= rd_issue;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        r_reg    <= r_next;
        rr_reg   <= rr_next;
        disc_reg <= disc_next;
        dy_reg   <= dy_next;
        dx_reg   <= dx_next;
        y_reg    <= y_next;
        x_reg    <= x_next;
        xend_reg <= xend_next;
        sum_reg  <= sum_next;
        gain_reg <= gain_next;
    end

    assign out_valid  = out_valid_reg;
    assign gain_count = gain_reg;

    // A read result only ever follows a scan cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> ($past(state_reg) == S_SCAN))
        else $error("cell read result without a scan cycle");

    // A scanned cell lies inside the clipped row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((x_reg >= 0) && (x_reg < xend_reg)
                                   && (y_reg >= 0) && (y_reg < h_reg)))
        else $error("scan position outside the clipped window");

    // No read is still in flight when the count is published.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !rd_vld_reg)
        else $error("count published with a read in flight");

    // The square root unit answers only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_rsp.done |-> (state_reg == S_SQRT))
        else $error("square root result outside its wait state");

    // An accepted query starts from a cleared count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (func == FUNC_QUERY)) |=> ((state_reg == S_ROW) && (sum_reg == 0)))
        else $error("query did not start from a cleared count");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the grid window unknown count block
// Sends cell write and window query words through the valid/ready input
// channel, predicts every window count from a local copy of the cell classes
// and the register settings, and checks each count word that comes out.
// Cells inside a query window are always written before the query is sent,
// so the block never reads a cell that holds no value.
// ----------------------------------------------------------------------------
module testbench;

    import gwuc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_TICKS = 7;
    localparam int SETTLE_TICKS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PCT    = 34;
    localparam int SMALL_MAP   = 48;

    // Clock, reset and block inputs, all known from time zero.
    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       func       = FUNC_WRITE;
    logic [FIELD_W-1:0]         column     = '0;
    logic [FIELD_W-1:0]         row        = '0;
    logic signed [VALUE_W-1:0]  cell_value = '0;
    logic                       out_ready  = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_W-1:0]           cfg_data   = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [OUT_W-1:0]    gain_count;

    // Local copy of the cell classes and of the register settings.
    logic [1:0]                 cell_class_model [MAP_DEPTH];
    bit                         cell_written [MAP_DEPTH];
    int                         cfg_map_width  = 512;
    int                         cfg_map_height = 512;
    int                         cfg_radius     = 10;
    logic                       cfg_shape      = SHAPE_RECT;

    // Counts still owed by the block, oldest first.
    logic signed [OUT_W-1:0]    gain_expected [$];
    logic signed [OUT_W-1:0]    expected_gain;
    int                         unwritten_cells [$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    bit                         steady_flow = 1'b0;

    grid_window_unknown_count u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .column     (column),
        .row        (row),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .gain_count (gain_count),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // The output side stalls at random unless steady flow is requested.
    always @(negedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Every count word taken by the bench is matched with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (gain_expected.size() == 0)
            begin
                $error("gain_count: no word expected, actual %0d", gain_count);
                error_count++;
            end
            else
            begin
                expected_gain = gain_expected.pop_front();
                if (gain_count !== expected_gain)
                begin
                    $error("gain_count: expected %0d, actual %0d", expected_gain, gain_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[grid_window_unknown_count] ERROR");
            $finish;
        end
    end

    function automatic int floor_sqrt(input int n);
        int root;
        root = 0;
        while ((root + 1) * (root + 1) <= n)
        begin
            root++;
        end
        return root;
    endfunction

    function automatic logic [1:0] value_class(input logic signed [VALUE_W-1:0] v);
        logic [1:0] c;
        if (v == -8'sd1 || (v > 8'sd45 && v < 8'sd55))
        begin
            c = CLS_UNKNOWN;
        end
        else if (v == 8'sd100)
        begin
            c = CLS_OCCUPIED;
        end
        else
        begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

    // Unknown minus occupied cells in the window around a centre; cells of
    // the window that were never written are listed instead of counted.
    function automatic int window_gain(input int c_col, input int c_row);
        int w;
        int h;
        int rad;
        int dy;
        int dx;
        int x;
        int y;
        int idx;
        int total;
        w = (cfg_map_width > MAX_COLUMNS) ? MAX_COLUMNS : cfg_map_width;
        h = (cfg_map_height > MAX_ROWS) ? MAX_ROWS : cfg_map_height;
        rad = (cfg_radius > MAX_RADIUS) ? MAX_RADIUS : cfg_radius;
        total = 0;
        unwritten_cells.delete();
        for (dy = -rad; dy <= rad; dy++)
        begin
            y = c_row + dy;
            dx = (cfg_shape == SHAPE_DISC) ? floor_sqrt(rad * rad - dy * dy) : rad;
            if (y >= 0 && y < h)
            begin
                for (x = c_col - dx; x < c_col + dx; x++)
                begin
                    if (x >= 0 && x < w)
                    begin
                        idx = y * MAX_COLUMNS + x;
                        if (!cell_written[idx])
                        begin
                            unwritten_cells.push_back(idx);
                        end
                        else if (cell_class_model[idx] == CLS_UNKNOWN)
                        begin
                            total++;
                        end
                        else if (cell_class_model[idx] == CLS_OCCUPIED)
                        begin
                            total--;
                        end
                    end
                end
            end
        end
        return total;
    endfunction

    // Values weighted toward the class boundaries.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = -8'sd1;
            1: v = VALUE_W'($urandom_range(45, 55));
            2: v = 8'sd100;
            default: v = VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // Mostly near the map in use, sometimes anywhere in the field range.
    function automatic int pick_coord(input int span);
        int c;
        if ($urandom_range(0, 99) < 70)
        begin
            c = $urandom_range(0, (span > 511) ? 511 : span);
        end
        else
        begin
            c = $urandom_range(0, 511);
        end
        return c;
    endfunction

    // Sends one word; called and returning at a falling edge. Valid stays
    // high on return, so the next call or a drain decides its next value.
    task automatic send_word(input logic f, input int c, input int r,
                             input logic signed [VALUE_W-1:0] v);
        int gain;
        logic signed [OUT_W-1:0] gain_word;
        gain_word = '0;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        column     <= FIELD_W'(c);
        row        <= FIELD_W'(r);
        cell_value <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (f == FUNC_WRITE)
        begin
            cell_class_model[r * MAX_COLUMNS + c] = value_class(v);
            cell_written[r * MAX_COLUMNS + c] = 1'b1;
        end
        else
        begin
            gain = window_gain(c, r);
            if (gain > GAIN_MAX)
            begin
                gain = GAIN_MAX;
            end
            if (gain < GAIN_MIN)
            begin
                gain = GAIN_MIN;
            end
            gain_word = OUT_W'(gain);
        end
        @(negedge clk);
        if (f == FUNC_QUERY)
        begin
            gain_expected.push_back(gain_word);
        end
    endtask

    // Writes every cell of the window that holds no value yet.
    task automatic cover_window(input int c_col, input int c_row, input bit all_unknown);
        int discard;
        int pending [$];
        discard = window_gain(c_col, c_row);
        pending = unwritten_cells;
        foreach (pending[i])
        begin
            send_word(FUNC_WRITE, pending[i] % MAX_COLUMNS, pending[i] / MAX_COLUMNS,
                      all_unknown ? -8'sd1 : pick_value());
        end
    endtask

    task automatic query_at(input int c_col, input int c_row);
        cover_window(c_col, c_row, 1'b0);
        send_word(FUNC_QUERY, c_col, c_row, VALUE_W'($urandom));
    endtask

    // Drops valid, waits for every owed count, then lets the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (gain_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(data);
        @(negedge clk);
        case (idx)
            REG_MAP_WIDTH:    cfg_map_width  = data & 'h3FF;
            REG_MAP_HEIGHT:   cfg_map_height = data & 'h3FF;
            REG_RADIUS_CELLS: cfg_radius     = data & 'h3F;
            REG_WINDOW_SHAPE: cfg_shape      = data[0];
            default:          cfg_shape      = cfg_shape;
        endcase
    endtask

    // Rewrites all four registers back to back; only called when idle.
    task automatic configure(input int w, input int h, input int rad, input logic shape);
        write_reg(REG_MAP_WIDTH, w);
        write_reg(REG_MAP_HEIGHT, h);
        write_reg(REG_RADIUS_CELLS, rad);
        write_reg(REG_WINDOW_SHAPE, shape);
        cfg_we <= 1'b0;
    endtask

    // Register values after reset, every value class, corner centres.
    task automatic test_reset_settings();
        logic signed [VALUE_W-1:0] probe_values [12];
        probe_values = '{-8'sd1, 8'sd45, 8'sd46, 8'sd50, 8'sd54, 8'sd55,
                         8'sd0, 8'sd99, 8'sd100, 8'sd101, -8'sd128, 8'sd127};
        foreach (probe_values[i])
        begin
            send_word(FUNC_WRITE, i % 6, i / 6, probe_values[i]);
        end
        send_word(FUNC_WRITE, 511, 511, 8'sd100);
        query_at(0, 0);
        query_at(511, 511);
        query_at(0, 511);
        query_at(511, 0);
        query_at(3, 1);
    endtask

    // Largest window, all unknown, with no idling on either side.
    task automatic test_full_window();
        wait_drained();
        steady_flow = 1'b1;
        configure(MAX_COLUMNS, MAX_ROWS, MAX_RADIUS, SHAPE_RECT);
        cover_window(100, 100, 1'b1);
        send_word(FUNC_QUERY, 100, 100, 8'sd0);
        wait_drained();
        configure(MAX_COLUMNS, MAX_ROWS, MAX_RADIUS, SHAPE_DISC);
        send_word(FUNC_QUERY, 100, 100, 8'sd0);
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // Empty window at radius zero up to the largest radius, both shapes.
    task automatic test_radius_range();
        wait_drained();
        configure(40, 40, 0, SHAPE_RECT);
        query_at(20, 20);
        query_at(0, 0);
        wait_drained();
        configure(40, 40, 1, SHAPE_DISC);
        query_at(20, 20);
        query_at(39, 0);
        wait_drained();
        configure(40, 40, MAX_RADIUS, SHAPE_RECT);
        query_at(20, 20);
        query_at(511, 511);
        wait_drained();
        configure(40, 40, MAX_RADIUS, SHAPE_DISC);
        query_at(39, 39);
        query_at(0, 20);
    endtask

    // Empty and oversized maps, a single cell map, writes and centres
    // outside the map in use.
    task automatic test_map_bounds();
        wait_drained();
        configure(0, MAX_ROWS, 10, SHAPE_RECT);
        query_at(5, 5);
        query_at(300, 2);
        wait_drained();
        configure(MAX_COLUMNS, 0, 10, SHAPE_DISC);
        query_at(5, 5);
        wait_drained();
        configure(1023, 1023, 4, SHAPE_DISC);
        query_at(509, 509);
        query_at(511, 3);
        wait_drained();
        configure(1, 1, 5, SHAPE_RECT);
        query_at(0, 0);
        query_at(4, 4);
        wait_drained();
        configure(20, 12, 6, SHAPE_RECT);
        send_word(FUNC_WRITE, 30, 30, 8'sd100);
        send_word(FUNC_WRITE, 25, 5, -8'sd1);
        query_at(25, 15);
        query_at(19, 11);
    endtask

    // One setting drawn at random, then a mix of writes and queries.
    task automatic random_phase(input int n_words);
        int w;
        int h;
        int rad;
        int eff_w;
        int eff_h;
        int k;
        k = $urandom_range(0, 9);
        w = (k == 0) ? 0 : (k == 1) ? 1023 : (k == 2) ? 512 : $urandom_range(1, SMALL_MAP);
        k = $urandom_range(0, 9);
        h = (k == 0) ? 0 : (k == 1) ? 1023 : (k == 2) ? 512 : $urandom_range(1, SMALL_MAP);
        eff_w = (w > MAX_COLUMNS) ? MAX_COLUMNS : w;
        eff_h = (h > MAX_ROWS) ? MAX_ROWS : h;
        // Large radii only on small maps, to keep the cell fill short.
        if (eff_w > SMALL_MAP || eff_h > SMALL_MAP)
        begin
            rad = $urandom_range(0, 8);
        end
        else
        begin
            rad = $urandom_range(0, MAX_RADIUS);
        end
        wait_drained();
        configure(w, h, rad, 1'($urandom_range(0, 1)));
        repeat (n_words)
        begin
            if ($urandom_range(0, 99) < 60)
            begin
                send_word(FUNC_WRITE, pick_coord(eff_w + 4), pick_coord(eff_h + 4),
                          pick_value());
            end
            else
            begin
                query_at(pick_coord(eff_w + rad), pick_coord(eff_h + rad));
            end
        end
    endtask

    task automatic test_random_traffic();
        repeat (4)
        begin
            random_phase(25);
        end
    endtask

    initial
    begin
        repeat (RESET_TICKS) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_settings();
        test_full_window();
        test_radius_range();
        test_map_bounds();
        test_random_traffic();
        wait_drained();
        if (error_count == 0)
        begin
            $display("[grid_window_unknown_count] OK");
        end
        else
        begin
            $display("[grid_window_unknown_count] ERROR");
        end
        $finish;
    end

endmodule
